/* design/sphere_point_query_unit_assert.svh */
// assertion helpers included by the top-level design file
`ifndef SPHERE_POINT_QUERY_UNIT_ASSERT_SVH
`define SPHERE_POINT_QUERY_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SPQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SPQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/spq_pkg.sv */
package spq_pkg;

  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X,
    CFG_CENTER_Y,
    CFG_CENTER_Z,
    CFG_RADIUS
  } spq_cfg_e;

  typedef struct packed {
    logic en;
    logic vld;
  } spq_ctl_t;

endpackage

/* design/spq_ifs.sv */
interface spq_point_if #(parameter int COORD_BITS = 31);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] point_x;
  logic [COORD_BITS-1:0] point_y;
  logic [COORD_BITS-1:0] point_z;
  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink (input valid, point_x, point_y, point_z, output ready);
endinterface

interface spq_result_if #(parameter int COORD_BITS = 31);
  logic                  valid;
  logic                  ready;
  logic                  inside_res;
  logic [COORD_BITS+1:0] surface_distance;
  logic [COORD_BITS-1:0] clamped_x;
  logic [COORD_BITS-1:0] clamped_y;
  logic [COORD_BITS-1:0] clamped_z;
  modport source (output valid, inside_res, surface_distance, clamped_x, clamped_y,
                  clamped_z, input ready);
  modport sink (input valid, inside_res, surface_distance, clamped_x, clamped_y,
                clamped_z, output ready);
endinterface

interface spq_cfg_if #(parameter int COORD_BITS = 31);
  logic                         valid;
  logic                         ready;
  logic [spq_pkg::CFG_IDX_W-1:0] index;
  logic [COORD_BITS-1:0]        data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* design/spq_sqrt.sv */
module spq_sqrt
  import spq_pkg::*;
#(
  parameter int QW     = 33,
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  spq_ctl_t          ctl_i,
  input  logic [2*QW-1:0]   sum_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              vld_o,
  output logic [QW-1:0]     root_o,
  output logic [SIDE_W-1:0] side_o
);

  logic                vld_q  [QW];
  logic [2*QW-1:0]     rad_q  [QW];
  logic [QW:0]         rem_q  [QW];
  logic [QW-1:0]       root_q [QW];
  logic [SIDE_W-1:0]   side_q [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic              vld_in;
    logic [2*QW-1:0]   rad_in;
    logic [QW:0]       rem_in;
    logic [QW-1:0]     root_in;
    logic [SIDE_W-1:0] side_in;
    logic [QW+2:0]     t;
    logic [QW+2:0]     trial;
    logic              ge;

    if (i == 0) begin : g_first
      assign vld_in  = ctl_i.vld;
      assign rad_in  = sum_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[i-1];
      assign rad_in  = rad_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign side_in = side_q[i-1];
    end

    assign t     = {rem_in, rad_in[2*QW-1 -: 2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign ge    = (t >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (ctl_i.en) begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        rad_q[i]  <= {rad_in[2*QW-3:0], 2'b00};
        rem_q[i]  <= ge ? (QW+1)'(t - trial) : t[QW:0];
        root_q[i] <= {root_in[QW-2:0], ge};
        side_q[i] <= side_in;
      end
    end
  end

  assign vld_o  = vld_q[QW-1];
  assign root_o = root_q[QW-1];
  assign side_o = side_q[QW-1];

endmodule

/* design/spq_div.sv */
module spq_div
  import spq_pkg::*;
#(
  parameter int DW     = 33,
  parameter int QTW    = 30,
  parameter int SIDE_W = 1,
  localparam int NW    = DW + QTW
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  spq_ctl_t                ctl_i,
  input  logic [2:0][NW-1:0]      num_i,
  input  logic [DW-1:0]           dv_i,
  input  logic [SIDE_W-1:0]       side_i,
  output logic                    vld_o,
  output logic [2:0][QTW-1:0]     quo_o,
  output logic [DW-1:0]           dv_o,
  output logic [SIDE_W-1:0]       side_o
);

  logic                  vld_q  [QTW];
  logic [2:0][DW-1:0]    rem_q  [QTW];
  logic [2:0][QTW-1:0]   lo_q   [QTW];
  logic [DW-1:0]         dv_q   [QTW];
  logic [SIDE_W-1:0]     side_q [QTW];

  for (genvar j = 0; j < QTW; j++) begin : g_stage
    logic                vld_in;
    logic [2:0][DW-1:0]  rem_in;
    logic [2:0][QTW-1:0] lo_in;
    logic [DW-1:0]       dv_in;
    logic [SIDE_W-1:0]   side_in;
    logic [2:0][DW-1:0]  rem_d;
    logic [2:0][QTW-1:0] lo_d;

    if (j == 0) begin : g_first
      assign vld_in  = ctl_i.vld;
      assign dv_in   = dv_i;
      assign side_in = side_i;
      for (genvar k = 0; k < 3; k++) begin : g_lane
        assign rem_in[k] = num_i[k][NW-1:QTW];
        assign lo_in[k]  = num_i[k][QTW-1:0];
      end
    end else begin : g_next
      assign vld_in  = vld_q[j-1];
      assign rem_in  = rem_q[j-1];
      assign lo_in   = lo_q[j-1];
      assign dv_in   = dv_q[j-1];
      assign side_in = side_q[j-1];
    end

    always_comb begin
      logic [DW:0] t;
      logic        ge;
      for (int k = 0; k < 3; k++) begin
        t        = {rem_in[k], lo_in[k][QTW-1]};
        ge       = (t >= {1'b0, dv_in});
        rem_d[k] = ge ? DW'(t - {1'b0, dv_in}) : t[DW-1:0];
        lo_d[k]  = {lo_in[k][QTW-2:0], ge};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (ctl_i.en) begin
        vld_q[j] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        rem_q[j]  <= rem_d;
        lo_q[j]   <= lo_d;
        dv_q[j]   <= dv_in;
        side_q[j] <= side_in;
      end
    end
  end

  assign vld_o  = vld_q[QTW-1];
  assign quo_o  = lo_q[QTW-1];
  assign dv_o   = dv_q[QTW-1];
  assign side_o = side_q[QTW-1];

endmodule

/* design/sphere_point_query_unit.sv */
// channel   dir  handshake       payload
// point_i   in   valid / ready   point_x, point_y, point_z
// result_o  out  valid / ready   inside_res, surface_distance, clamped_x/y/z
// cfg_i     in   valid / ready   index, data (always ready)
//
// one item per cycle while the output is not stalled
// the pipeline runs through the bit-per-stage square root and the bit-per-stage dividers
// reset clears all valid bits and the sphere registers
// a stalled output freezes the whole pipeline; nothing is lost or repeated
`include "sphere_point_query_unit_assert.svh"

module sphere_point_query_unit
  import spq_pkg::*;
#(
  parameter int COORD_BITS = 31
) (
  input  logic clk_i,
  input  logic rst_ni,
  spq_point_if.sink    point_i,
  spq_result_if.source result_o,
  spq_cfg_if.sink      cfg_i
);

  localparam int CB  = COORD_BITS;
  localparam int MW  = CB + 1;
  localparam int QW  = MW + 1;
  localparam int SW  = 2 * QW;
  localparam int RW  = CB - 1;
  localparam int NW  = QW + RW;

  localparam logic signed [CB+1:0] CHI = {3'b000, {(CB-1){1'b1}}};
  localparam logic signed [CB+1:0] CLO = {3'b111, {(CB-1){1'b0}}};
  localparam logic signed [CB+2:0] SHI = {2'b00, {(CB+1){1'b1}}};
  localparam logic signed [CB+2:0] SLO = {2'b11, {(CB+1){1'b0}}};

  typedef struct packed {
    logic [2:0][CB-1:0] pnt;
    logic [2:0][MW-1:0] mag;
    logic [2:0]         neg;
    logic               contained;
  } side_a_t;

  typedef struct packed {
    logic [2:0][CB-1:0] pnt;
    logic [2:0]         neg;
    logic               contained;
  } side_b_t;

  logic [2:0][CB-1:0] center_q;
  logic [RW-1:0]      radius_q;

  logic en;

  // configuration
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q <= '0;
      radius_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (spq_cfg_e'(cfg_i.index))
        CFG_CENTER_X: center_q[0] <= cfg_i.data;
        CFG_CENTER_Y: center_q[1] <= cfg_i.data;
        CFG_CENTER_Z: center_q[2] <= cfg_i.data;
        CFG_RADIUS:   radius_q    <= cfg_i.data[RW-1:0];
        default: ;
      endcase
    end
  end

  // stage 1: offsets and magnitudes
  logic [2:0][CB-1:0] pnt_in;
  logic [2:0][MW-1:0] mag_d;
  logic [2:0]         neg_d;

  assign pnt_in = {point_i.point_z, point_i.point_y, point_i.point_x};

  always_comb begin
    logic signed [CB:0] d;
    for (int k = 0; k < 3; k++) begin
      d        = $signed({pnt_in[k][CB-1], pnt_in[k]}) -
                 $signed({center_q[k][CB-1], center_q[k]});
      neg_d[k] = d[CB];
      mag_d[k] = d[CB] ? MW'(-d) : MW'(d);
    end
  end

  logic               s1_vld_q;
  logic [2:0][CB-1:0] s1_pnt_q;
  logic [2:0][MW-1:0] s1_mag_q;
  logic [2:0]         s1_neg_q;

  // stage 2: squares
  logic                 s2_vld_q;
  logic [2:0][2*MW-1:0] s2_sq_q;
  logic [2*RW-1:0]      s2_rr_q;
  logic [2:0][CB-1:0]   s2_pnt_q;
  logic [2:0][MW-1:0]   s2_mag_q;
  logic [2:0]           s2_neg_q;

  // stage 3: sum and containment
  logic          s3_vld_q;
  logic [SW-1:0] s3_sum_q;
  side_a_t       s3_side_q;
  logic [SW-1:0] sum_d;

  assign sum_d = SW'(s2_sq_q[0]) + SW'(s2_sq_q[1]) + SW'(s2_sq_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= point_i.valid;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_pnt_q <= pnt_in;
      s1_mag_q <= mag_d;
      s1_neg_q <= neg_d;
      for (int k = 0; k < 3; k++) begin
        s2_sq_q[k] <= s1_mag_q[k] * s1_mag_q[k];
      end
      s2_rr_q  <= radius_q * radius_q;
      s2_pnt_q <= s1_pnt_q;
      s2_mag_q <= s1_mag_q;
      s2_neg_q <= s1_neg_q;
      s3_sum_q            <= sum_d;
      s3_side_q.pnt       <= s2_pnt_q;
      s3_side_q.mag       <= s2_mag_q;
      s3_side_q.neg       <= s2_neg_q;
      s3_side_q.contained <= (sum_d <= SW'(s2_rr_q));
    end
  end

  // square root
  logic    sq_vld;
  logic [QW-1:0] sq_root;
  side_a_t sq_side;

  spq_sqrt #(
    .QW     (QW),
    .SIDE_W ($bits(side_a_t))
  ) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (spq_ctl_t'{en: en, vld: s3_vld_q}),
    .sum_i  (s3_sum_q),
    .side_i (s3_side_q),
    .vld_o  (sq_vld),
    .root_o (sq_root),
    .side_o (sq_side)
  );

  // stage 4: scale by radius; stage 5: rounding offset
  logic                  s4_vld_q;
  logic [2:0][MW+RW-1:0] s4_prod_q;
  logic [QW-1:0]         s4_dist_q;
  side_b_t               s4_side_q;
  logic                  s5_vld_q;
  logic [2:0][NW-1:0]    s5_num_q;
  logic [QW-1:0]         s5_dist_q;
  side_b_t               s5_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
    end else if (en) begin
      s4_vld_q <= sq_vld;
      s5_vld_q <= s4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s4_prod_q[k] <= sq_side.mag[k] * radius_q;
        s5_num_q[k]  <= NW'(s4_prod_q[k]) + NW'(s4_dist_q[QW-1:1]);
      end
      s4_dist_q           <= sq_root;
      s4_side_q.pnt       <= sq_side.pnt;
      s4_side_q.neg       <= sq_side.neg;
      s4_side_q.contained <= sq_side.contained;
      s5_dist_q           <= s4_dist_q;
      s5_side_q           <= s4_side_q;
    end
  end

  // division
  logic               dv_vld;
  logic [2:0][RW-1:0] dv_quo;
  logic [QW-1:0]      dv_dist;
  side_b_t            dv_side;

  spq_div #(
    .DW     (QW),
    .QTW    (RW),
    .SIDE_W ($bits(side_b_t))
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (spq_ctl_t'{en: en, vld: s5_vld_q}),
    .num_i  (s5_num_q),
    .dv_i   (s5_dist_q),
    .side_i (s5_side_q),
    .vld_o  (dv_vld),
    .quo_o  (dv_quo),
    .dv_o   (dv_dist),
    .side_o (dv_side)
  );

  // output stage
  logic [2:0][CB-1:0] res_d;
  logic [CB+1:0]      surf_d;

  always_comb begin
    logic signed [CB+1:0] qe;
    logic signed [CB+1:0] v;
    logic signed [CB+2:0] se;
    for (int k = 0; k < 3; k++) begin
      qe = $signed({{(CB+2-RW){1'b0}}, dv_quo[k]});
      v  = $signed({{2{center_q[k][CB-1]}}, center_q[k]}) + (dv_side.neg[k] ? -qe : qe);
      if (dv_side.contained) begin
        res_d[k] = dv_side.pnt[k];
      end else if (v > CHI) begin
        res_d[k] = CHI[CB-1:0];
      end else if (v < CLO) begin
        res_d[k] = CLO[CB-1:0];
      end else begin
        res_d[k] = v[CB-1:0];
      end
    end
    se = $signed({1'b0, dv_dist}) - $signed({{(CB+3-RW){1'b0}}, radius_q});
    if (se > SHI) begin
      surf_d = SHI[CB+1:0];
    end else if (se < SLO) begin
      surf_d = SLO[CB+1:0];
    end else begin
      surf_d = se[CB+1:0];
    end
  end

  logic               out_vld_q;
  logic               out_inside_q;
  logic [CB+1:0]      out_surf_q;
  logic [2:0][CB-1:0] out_res_q;

  assign en            = !out_vld_q || result_o.ready;
  assign point_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_inside_q <= dv_side.contained;
      out_surf_q   <= surf_d;
      out_res_q    <= res_d;
    end
  end

  assign result_o.valid            = out_vld_q;
  assign result_o.inside_res       = out_inside_q;
  assign result_o.surface_distance = out_surf_q;
  assign result_o.clamped_x        = out_res_q[0];
  assign result_o.clamped_y        = out_res_q[1];
  assign result_o.clamped_z        = out_res_q[2];

  `SPQ_ASSERT_IMP(a_inside_not_beyond, out_vld_q && out_inside_q,
                  out_surf_q[CB+1] || (out_surf_q == '0), "inside item beyond surface")
  `SPQ_ASSERT_IMP(a_outside_not_within, out_vld_q && !out_inside_q,
                  !out_surf_q[CB+1], "outside item within surface")
  `SPQ_ASSERT_IMP(a_zero_radius_center, out_vld_q && !out_inside_q && (radius_q == '0),
                  out_res_q == center_q, "empty sphere clamp missed centre")
  `SPQ_ASSERT_NXT(a_stall_freezes, out_vld_q && !result_o.ready,
                  $stable(out_res_q) && $stable(out_surf_q), "stalled item changed")

endmodule

/* test/spq_checker.sv */
`timescale 1ns / 100ps

module spq_checker
  import spq_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  spq_point_if   point_i,
  spq_result_if  result_i,
  spq_cfg_if     cfg_i,
  output int     errors_o,
  output int     pending_o,
  output int     results_o,
  output int     clamped_o
);

  typedef struct packed {
    logic        contained;
    logic [32:0] surf;
    logic [30:0] cx;
    logic [30:0] cy;
    logic [30:0] cz;
  } query_t;

  logic [30:0] ctr_x, ctr_y, ctr_z;
  logic [29:0] radius;
  query_t      expected_q[$];

  function automatic logic signed [63:0] widen(logic [30:0] v);
    return {{33{v[30]}}, v};
  endfunction

  function automatic logic [30:0] sat_coord(logic signed [63:0] v);
    if (v > 64'sd1073741823) return 31'h3fffffff;
    if (v < -64'sd1073741824) return 31'h40000000;
    return v[30:0];
  endfunction

  function automatic query_t sphere_query(logic [30:0] px, logic [30:0] py, logic [30:0] pz);
    logic signed [63:0] p[3];
    logic signed [63:0] c[3];
    logic signed [63:0] d[3];
    logic signed [63:0] sq, sd;
    logic [127:0] s, m, r, cand, root, qv;
    logic [30:0] o[3];
    query_t res;
    p[0] = widen(px); p[1] = widen(py); p[2] = widen(pz);
    c[0] = widen(ctr_x); c[1] = widen(ctr_y); c[2] = widen(ctr_z);
    r = {98'd0, radius};
    s = '0;
    for (int k = 0; k < 3; k++) begin
      d[k] = p[k] - c[k];
      m = d[k] < 0 ? 128'(-d[k]) : 128'(d[k]);
      s = s + m * m;
      o[k] = px;
    end
    o[0] = px; o[1] = py; o[2] = pz;
    res.contained = s <= r * r;
    root = '0;
    for (int b = 62; b >= 0; b--) begin
      cand = root | (128'd1 << b);
      if (cand * cand <= s) root = cand;
    end
    if (!res.contained) begin
      for (int k = 0; k < 3; k++) begin
        m = d[k] < 0 ? 128'(-d[k]) : 128'(d[k]);
        qv = (m * r + (root >> 1)) / root;
        sq = d[k] < 0 ? -$signed(qv[63:0]) : $signed(qv[63:0]);
        o[k] = sat_coord(c[k] + sq);
      end
    end
    sd = $signed(root[63:0]) - $signed(r[63:0]);
    if (sd > 64'sd4294967295) res.surf = 33'h0ffffffff;
    else if (sd < -64'sd4294967296) res.surf = 33'h100000000;
    else res.surf = sd[32:0];
    res.cx = o[0]; res.cy = o[1]; res.cz = o[2];
    return res;
  endfunction

  assign pending_o = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    query_t want;
    query_t got;
    if (!rst_ni) begin
      ctr_x <= '0; ctr_y <= '0; ctr_z <= '0; radius <= '0;
      errors_o <= 0; results_o <= 0; clamped_o <= 0;
      expected_q.delete();
    end else begin
      if (point_i.valid && point_i.ready)
        expected_q.push_back(sphere_query(point_i.point_x, point_i.point_y, point_i.point_z));
      if (result_i.valid && result_i.ready) begin
        got = '{result_i.inside_res, result_i.surface_distance, result_i.clamped_x,
                result_i.clamped_y, result_i.clamped_z};
        results_o <= results_o + 1;
        if (!got.contained) clamped_o <= clamped_o + 1;
        if (expected_q.size() == 0) begin
          if (errors_o < 10) $display("unexpected result item %p", got);
          errors_o <= errors_o + 1;
        end else begin
          want = expected_q.pop_front();
          if (want != got) begin
            if (errors_o < 10)
              $display("mismatch at %0t: expected %p, got %p", $realtime, want, got);
            errors_o <= errors_o + 1;
          end
        end
      end
      if (cfg_i.valid && cfg_i.ready) begin
        case (spq_cfg_e'(cfg_i.index))
          CFG_CENTER_X: ctr_x <= cfg_i.data;
          CFG_CENTER_Y: ctr_y <= cfg_i.data;
          CFG_CENTER_Z: ctr_z <= cfg_i.data;
          CFG_RADIUS:   radius <= cfg_i.data[29:0];
          default: ;
        endcase
      end
    end
  end

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps

module testbench
  import spq_pkg::*;
;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic calm = 1'b0;
  int   errors, pending, results, clamped;
  logic [30:0] cur_cx, cur_cy, cur_cz;
  logic [29:0] cur_r;

  spq_point_if  #(31) point_ch();
  spq_result_if #(31) result_ch();
  spq_cfg_if    #(31) cfg_ch();

  sphere_point_query_unit #(.COORD_BITS(31)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .point_i(point_ch.sink), .result_o(result_ch.source), .cfg_i(cfg_ch.sink)
  );

  spq_checker checker_inst (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .point_i(point_ch), .result_i(result_ch), .cfg_i(cfg_ch),
    .errors_o(errors), .pending_o(pending), .results_o(results), .clamped_o(clamped)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("DONE: errors detected");
    $finish;
  end

  // result side back-pressure
  initial begin
    int n;
    result_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      n = calm ? 0 : $urandom_range(0, 16);
      if (n > 0) begin
        result_ch.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!result_ch.valid) @(posedge clk_i);
    end
  end

  task automatic send_point(logic [30:0] x, logic [30:0] y, logic [30:0] z);
    int n;
    n = calm ? 0 : $urandom_range(0, 16);
    if (n > 0) begin
      point_ch.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    point_ch.valid <= 1'b1;
    point_ch.point_x <= x;
    point_ch.point_y <= y;
    point_ch.point_z <= z;
    @(posedge clk_i);
    while (!point_ch.ready) @(posedge clk_i);
  endtask

  task automatic write_reg(spq_cfg_e idx, logic [30:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_sphere(logic [30:0] x, logic [30:0] y, logic [30:0] z, logic [30:0] r);
    point_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    write_reg(CFG_CENTER_X, x);
    write_reg(CFG_CENTER_Y, y);
    write_reg(CFG_CENTER_Z, z);
    write_reg(CFG_RADIUS, r);
    cur_cx = x; cur_cy = y; cur_cz = z; cur_r = r[29:0];
  endtask

  function automatic logic [30:0] near(logic [30:0] c, logic [29:0] r);
    int span;
    span = (r > 30'd2000000) ? 2000000 : int'(r) + 8;
    case ($urandom_range(0, 3))
      0: return c + 31'($urandom_range(0, 2 * span)) - 31'(span);
      1: return c + 31'(r) - 31'($urandom_range(0, 3));
      2: return c - 31'(r) + 31'($urandom_range(0, 3));
      default: return 31'($urandom);
    endcase
  endfunction

  initial begin
    logic [30:0] u;
    point_ch.valid <= 1'b0;
    point_ch.point_x <= '0;
    point_ch.point_y <= '0;
    point_ch.point_z <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_CENTER_X;
    cfg_ch.data <= '0;
    cur_cx = '0; cur_cy = '0; cur_cz = '0; cur_r = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty sphere after reset
    send_point('0, '0, '0);
    send_point(31'd1, '0, '0);
    send_point(31'h3fffffff, 31'h3fffffff, 31'h3fffffff);
    send_point(31'h40000000, 31'h40000000, 31'h40000000);
    set_sphere('0, '0, '0, 31'h10000);
    send_point(31'h10000, '0, '0);
    send_point(31'h10001, '0, '0);
    send_point(31'h7fff0000, '0, '0);
    send_point(31'h8000, 31'h8000, 31'h7fff8000);
    send_point(31'h3fffffff, 31'h40000000, 31'h3fffffff);
    set_sphere(31'h3fffffff, 31'h3fffffff, 31'h3fffffff, 31'h3fffffff);
    send_point(31'h40000000, 31'h40000000, 31'h40000000);
    send_point(31'h3fffffff, 31'h3fffffff, 31'h3fffffff);
    send_point('0, '0, '0);
    set_sphere(31'h40000000, 31'h40000000, 31'h40000000, '0);
    send_point(31'h3fffffff, 31'h3fffffff, 31'h3fffffff);
    send_point(31'h40000000, 31'h40000000, 31'h40000000);
    send_point(31'h40000001, 31'h40000000, 31'h40000000);
    set_sphere(31'h40000000, 31'h3fffffff, '0, 31'h3fffffff);
    send_point(31'h3fffffff, 31'h40000000, 31'h3fffffff);
    send_point(31'h40000000, 31'h3fffffff, 31'h40000000);

    for (int ph = 0; ph < 17; ph++) begin
      calm = (ph % 4 == 3);
      u = 31'($urandom);
      case (ph % 3)
        0: u = {1'b0, 30'($urandom_range(0, 1 << 20))};
        1: u = {1'b0, 30'($urandom_range(0, 1 << 27))};
        default: u = {1'b0, u[29:0]};
      endcase
      if (ph == 5) u = '0;
      set_sphere(31'($urandom), 31'($urandom), 31'($urandom), u);
      for (int i = 0; i < 50; i++) begin
        if ($urandom_range(0, 9) < 7)
          send_point(near(cur_cx, cur_r), near(cur_cy, cur_r), near(cur_cz, cur_r));
        else
          send_point(31'($urandom), 31'($urandom), 31'($urandom));
      end
    end
    point_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    $display("checked %0d result items over 22 sphere settings, %0d of them clamped",
             results, clamped);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches", errors);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
